FILE: rtl/tcts_pkg.sv
// Shared types and constants for the text console teletype block.
// Command codes, field widths and the fixed cell and character values.
// No dependencies.
package tcts_pkg;

  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CNT_W  = 8;
  localparam int CELL_W = 16;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_TTY       = 3'd0,
    CMD_SET_CUR   = 3'd1,
    CMD_READ      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_SCROLL_UP = 3'd4,
    CMD_SCROLL_DN = 3'd5
  } cmd_t;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] DEFAULT_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] CHAR_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR      = 8'd13;

endpackage

FILE: rtl/text_console_teletype_scroll.sv
// Text console: ROWS x COLUMNS cell store with cursor, teletype output and window scrolls.
// Uses tcts_pkg for command codes, field widths and blank cell values.
// After reset the block blanks the store to 0x0720, one cell a cycle, over all ROWS*COLUMNS
// cells before it takes the first request. All cell traffic goes through a single-port
// store with registered read data, so the time a request takes follows the cells it touches:
// a printed character is a read-modify-write of the cursor cell, and a newline blanks each
// cell from the cursor to the line end. A window scroll walks the window row by row, writing
// each blanked cell and reading then writing each moved cell; a teletype wrap past the bottom
// row scrolls the full screen. One request is worked on at a time; the next is taken while
// the previous result waits in the output register.
module text_console_teletype_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] char_code, [15:8] attribute, [20:16] top_row, [27:21] left_col,
  // [32:28] bottom_row, [39:33] right_col, [47:40] line_count
  input  logic [tcts_pkg::IN_DATA_W-1:0]     in_tdata,
  // [2:0] cmd
  input  logic [tcts_pkg::CMD_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] cell_value, [20:16] cursor_row, [27:21] cursor_col, [28] error
  output logic [tcts_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = tcts_pkg::ROW_W;
  localparam int COL_W  = tcts_pkg::COL_W;
  localparam int CNT_W  = tcts_pkg::CNT_W;
  localparam int CELL_W = tcts_pkg::CELL_W;
  localparam int CHAR_W = tcts_pkg::CHAR_W;

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_READ_WAIT, S_RMW_RD, S_RMW_WR, S_ADVANCE,
    S_ROW_START, S_FILL, S_MOVE_RD, S_MOVE_WR, S_ROW_END, S_DONE
  } state_t;

  state_t                    state_r;
  logic [ADDR_W-1:0]         clr_addr_r;
  logic [ROW_W-1:0]          cur_row_r;
  logic [COL_W-1:0]          cur_col_r;
  logic                      out_tvalid_r;
  logic [tcts_pkg::OUT_DATA_W-1:0] out_tdata_r;

  logic [tcts_pkg::CMD_W-1:0] cmd_r;
  logic [CHAR_W-1:0]         ch_r;
  logic [CELL_W-1:0]         value_r;
  logic                      err_r;
  logic                      adv_r;    // newline fill: advance cursor when window finishes
  logic [COL_W-1:0]          rmw_col_r;

  // window walker
  logic [ROW_W-1:0]          w_top_r, w_bot_r, w_row_r, w_src_r;
  logic [COL_W-1:0]          w_left_r, w_right_r, w_col_r;
  logic [CNT_W-1:0]          w_cnt_r;
  logic [CELL_W-1:0]         w_blank_r;
  logic                      w_down_r;

  logic [CELL_W-1:0]         cells_mem [CELLS];
  logic [CELL_W-1:0]         rd_data_r;

  logic                      mem_we, mem_re;
  logic [ADDR_W-1:0]         mem_addr;
  logic [CELL_W-1:0]         mem_wdata;
  logic [ROW_W-1:0]          a_row;
  logic [COL_W-1:0]          a_col;
  logic [CHAR_W-1:0]         rmw_char;
  logic                      row_fill;
  logic [ROW_W-1:0]          src_row;
  logic [ROW_W:0]            bad_bot;
  logic                      bad_window;
  logic [ROW_W+CNT_W-4:0]    row_plus_cnt, top_plus_cnt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign rmw_char = (ch_r == tcts_pkg::CHAR_BS) ? tcts_pkg::SPACE_CHAR : ch_r;

  // row decision for the window walker
  assign row_plus_cnt = (ROW_W+CNT_W-3)'(w_row_r) + (ROW_W+CNT_W-3)'(w_cnt_r);
  assign top_plus_cnt = (ROW_W+CNT_W-3)'(w_top_r) + (ROW_W+CNT_W-3)'(w_cnt_r);
  assign src_row = w_down_r ? (w_row_r - w_cnt_r[ROW_W-1:0])
                            : (w_row_r + w_cnt_r[ROW_W-1:0]);
  always_comb begin
    if (w_cnt_r == '0) begin
      row_fill = 1'b1;
    end else if (w_down_r) begin
      row_fill = (ROW_W+CNT_W-3)'(w_row_r) < top_plus_cnt;
    end else begin
      row_fill = row_plus_cnt > (ROW_W+CNT_W-3)'(w_bot_r);
    end
  end

  assign bad_bot    = {1'b0, w_bot_r};
  assign bad_window = (w_top_r > w_bot_r) || (w_left_r > w_right_r) ||
                      (32'(bad_bot) >= 32'(ROWS)) || (32'(w_right_r) >= 32'(COLUMNS));

  // store port control
  always_comb begin
    a_row     = cur_row_r;
    a_col     = cur_col_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = w_blank_r;
    case (state_r)
      S_EXEC: begin
        mem_re    = (cmd_r == tcts_pkg::CMD_READ);
        mem_we    = (cmd_r == tcts_pkg::CMD_WRITE);
        mem_wdata = {w_blank_r[CELL_W-1:CHAR_W], ch_r};
      end
      S_RMW_RD: begin
        a_col  = rmw_col_r;
        mem_re = 1'b1;
      end
      S_RMW_WR: begin
        a_col     = rmw_col_r;
        mem_we    = 1'b1;
        mem_wdata = {rd_data_r[CELL_W-1:CHAR_W], rmw_char};
      end
      S_FILL: begin
        a_row  = w_row_r;
        a_col  = w_col_r;
        mem_we = 1'b1;
      end
      S_MOVE_RD: begin
        a_row  = w_src_r;
        a_col  = w_col_r;
        mem_re = 1'b1;
      end
      S_MOVE_WR: begin
        a_row     = w_row_r;
        a_col     = w_col_r;
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = tcts_pkg::BLANK_CELL;
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = (state_r == S_CLEAR) ? clr_addr_r
                  : ADDR_W'(32'(a_row) * 32'(COLUMNS) + 32'(a_col));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= cells_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      out_tvalid_r <= 1'b0;
      adv_r        <= 1'b0;
    end else begin
      // S_DONE handles the output register itself
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r     <= in_tuser;
            ch_r      <= in_tdata[7:0];
            w_blank_r <= {in_tdata[15:8], tcts_pkg::SPACE_CHAR};
            w_top_r   <= in_tdata[20:16];
            w_left_r  <= in_tdata[27:21];
            w_bot_r   <= in_tdata[32:28];
            w_right_r <= in_tdata[39:33];
            w_cnt_r   <= in_tdata[47:40];
            err_r     <= 1'b0;
            value_r   <= '0;
            adv_r     <= 1'b0;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_r)
            tcts_pkg::CMD_TTY: begin
              if (ch_r == tcts_pkg::CHAR_CR) begin
                state_r <= S_DONE;
              end else if (ch_r == tcts_pkg::CHAR_LF) begin
                // blank from cursor to line end, then advance
                w_top_r   <= cur_row_r;
                w_bot_r   <= cur_row_r;
                w_row_r   <= cur_row_r;
                w_left_r  <= cur_col_r;
                w_right_r <= LAST_COL;
                w_cnt_r   <= '0;
                w_blank_r <= tcts_pkg::BLANK_CELL;
                w_down_r  <= 1'b0;
                adv_r     <= 1'b1;
                state_r   <= S_ROW_START;
              end else begin
                rmw_col_r <= cur_col_r;
                state_r   <= S_RMW_RD;
              end
            end
            tcts_pkg::CMD_SET_CUR: begin
              if ((32'(w_top_r) >= 32'(ROWS)) || (32'(w_left_r) >= 32'(COLUMNS))) begin
                err_r <= 1'b1;
              end else begin
                cur_row_r <= w_top_r;
                cur_col_r <= w_left_r;
              end
              state_r <= S_DONE;
            end
            tcts_pkg::CMD_READ: begin
              state_r <= S_READ_WAIT;
            end
            tcts_pkg::CMD_WRITE: begin
              state_r <= S_DONE;
            end
            tcts_pkg::CMD_SCROLL_UP, tcts_pkg::CMD_SCROLL_DN: begin
              if (bad_window) begin
                err_r   <= 1'b1;
                state_r <= S_DONE;
              end else begin
                w_down_r <= (cmd_r == tcts_pkg::CMD_SCROLL_DN);
                w_row_r  <= (cmd_r == tcts_pkg::CMD_SCROLL_DN) ? w_bot_r : w_top_r;
                state_r  <= S_ROW_START;
              end
            end
            default: begin
              err_r   <= 1'b1;
              state_r <= S_DONE;
            end
          endcase
        end
        S_READ_WAIT: begin
          value_r <= rd_data_r;
          state_r <= S_DONE;
        end
        S_RMW_RD: begin
          state_r <= S_RMW_WR;
        end
        S_RMW_WR: begin
          if (ch_r == tcts_pkg::CHAR_BS) begin
            // backspace blanks the cursor cell, then the one before it unless the cursor is in column 0
            if ((rmw_col_r == cur_col_r) && (cur_col_r != '0)) begin
              rmw_col_r <= cur_col_r - 1'b1;
              state_r   <= S_RMW_RD;
            end else begin
              cur_col_r <= rmw_col_r;
              state_r   <= S_DONE;
            end
          end else begin
            state_r <= S_ADVANCE;
          end
        end
        S_ADVANCE: begin
          if ((ch_r != tcts_pkg::CHAR_LF) && (cur_col_r != LAST_COL)) begin
            cur_col_r <= cur_col_r + 1'b1;
            state_r   <= S_DONE;
          end else begin
            cur_col_r <= '0;
            if (cur_row_r == LAST_ROW) begin
              // past the bottom: scroll whole screen up one line
              w_top_r   <= '0;
              w_bot_r   <= LAST_ROW;
              w_row_r   <= '0;
              w_left_r  <= '0;
              w_right_r <= LAST_COL;
              w_cnt_r   <= CNT_W'(1);
              w_blank_r <= tcts_pkg::BLANK_CELL;
              w_down_r  <= 1'b0;
              adv_r     <= 1'b0;
              state_r   <= S_ROW_START;
            end else begin
              cur_row_r <= cur_row_r + 1'b1;
              state_r   <= S_DONE;
            end
          end
        end
        S_ROW_START: begin
          w_col_r <= w_left_r;
          w_src_r <= src_row;
          state_r <= row_fill ? S_FILL : S_MOVE_RD;
        end
        S_FILL: begin
          if (w_col_r == w_right_r) begin
            state_r <= S_ROW_END;
          end else begin
            w_col_r <= w_col_r + 1'b1;
          end
        end
        S_MOVE_RD: begin
          state_r <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          if (w_col_r == w_right_r) begin
            state_r <= S_ROW_END;
          end else begin
            w_col_r <= w_col_r + 1'b1;
            state_r <= S_MOVE_RD;
          end
        end
        S_ROW_END: begin
          if (w_down_r ? (w_row_r == w_top_r) : (w_row_r == w_bot_r)) begin
            state_r <= adv_r ? S_ADVANCE : S_DONE;
          end else begin
            w_row_r <= w_down_r ? (w_row_r - 1'b1) : (w_row_r + 1'b1);
            state_r <= S_ROW_START;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {3'b000, err_r, cur_col_r, cur_row_r, value_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
